// ===== hdl/bts_pkg.sv =====
// Shared types and constants of the buzzer tone sequencer.
`default_nettype none

package bts_pkg;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_STOP    = 3'd1,
		OP_TURN_ON = 3'd2,
		OP_BEEP    = 3'd3,
		OP_LOAD    = 3'd4,
		OP_ARRAY   = 3'd5
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] tone_hz;
		logic [15:0] period_ms;
		logic        loop_on;
		logic [6:0]  entry_count;
	} item_t;

	typedef struct packed {
		logic [9:0] tick_ms;
		logic       passive;
	} cfg_t;

	typedef struct packed {
		logic [15:0] period_ms;
		logic [15:0] tone_hz;
	} entry_t;

	typedef struct packed {
		logic        gpio_level;
		logic [15:0] tone_hz;
		logic        playing;
		logic        done;
	} result_t;

	localparam logic       REG_TICK_MS   = 1'b0;
	localparam logic       REG_PASSIVE   = 1'b1;
	localparam logic [9:0] TICK_MS_RESET = 10'd1;
	localparam int         BEEP_STEPS    = 2;

endpackage

`default_nettype wire

// ===== hdl/bts_table.sv =====
// Step table memory holding the duration and tone of each array step.
`default_nettype none

module bts_table
	import bts_pkg::*;
#(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bts_seq.sv =====
// Sequencer state, per-command update stage and result register.
`default_nettype none

module bts_seq
	import bts_pkg::*;
#(
	parameter int DEPTH = 64,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfg_t          cfg,
	input  wire logic          item_valid,
	output logic               item_ready,
	input  wire item_t         item,
	input  wire entry_t        rd_data,
	output logic [CW-1:0]      idx_after,
	output logic               res_valid,
	input  wire logic          res_ready,
	output result_t            res
);

	localparam int NW = (CW > 7) ? CW : 7;

	item_t         item_s1;
	logic          valid_s1;
	logic          move;

	logic [31:0]   el_q, el_n;
	logic [CW-1:0] idx_q, idx_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [15:0]   time_q, time_n;
	logic [15:0]   hz_q, hz_n;
	logic          loop_q, loop_n;
	logic          table_q, table_n;
	logic          play_q, play_n;
	logic          lvl_q, lvl_n;
	logic [15:0]   dhz_q, dhz_n;
	logic          done_n;

	logic [32:0]   sum;
	logic [31:0]   el_sat;
	logic [CW:0]   step_inc;
	logic [CW:0]   nx;

	result_t       res_q;
	logic          res_valid_q;

	assign move       = valid_s1 && (!res_valid_q || res_ready);
	assign item_ready = !valid_s1 || move;
	assign idx_after  = valid_s1 ? idx_n : idx_q;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_comb begin
		el_n     = el_q;
		idx_n    = idx_q;
		cnt_n    = cnt_q;
		time_n   = time_q;
		hz_n     = hz_q;
		loop_n   = loop_q;
		table_n  = table_q;
		play_n   = play_q;
		lvl_n    = lvl_q;
		dhz_n    = dhz_q;
		done_n   = 1'b0;
		sum      = {1'b0, el_q} + 33'(cfg.tick_ms);
		el_sat   = sum[32] ? '1 : sum[31:0];
		step_inc = (CW+1)'(idx_q) + (CW+1)'(1);
		nx       = step_inc;
		case (item_s1.op)
			OP_TICK: begin
				el_n = el_sat;
				if (play_q && (cnt_q != '0) && (el_sat > 32'(time_q))) begin
					el_n = '0;
					if (step_inc < (CW+1)'(cnt_q)) begin
						if (!table_q) begin
							if (loop_q) begin
								nx = (CW+1)'(step_inc[0]);
							end
							if (nx[0]) begin
								lvl_n = 1'b0;
								dhz_n = '0;
							end else begin
								lvl_n = !cfg.passive;
								dhz_n = cfg.passive ? hz_q : 16'd0;
							end
						end else begin
							time_n = rd_data.period_ms;
							hz_n   = rd_data.tone_hz;
							lvl_n  = !cfg.passive;
							dhz_n  = cfg.passive ? rd_data.tone_hz : 16'd0;
						end
						idx_n = CW'(nx);
					end else begin
						idx_n  = CW'(step_inc);
						lvl_n  = 1'b0;
						dhz_n  = '0;
						play_n = 1'b0;
						done_n = 1'b1;
					end
				end
			end
			OP_STOP: begin
				play_n = 1'b0;
				lvl_n  = 1'b0;
				dhz_n  = '0;
			end
			OP_TURN_ON: begin
				el_n   = '0;
				play_n = 1'b1;
				loop_n = 1'b0;
				cnt_n  = '0;
				if (cfg.passive) begin
					hz_n = item_s1.tone_hz;
				end
				lvl_n = !cfg.passive;
				dhz_n = cfg.passive ? item_s1.tone_hz : 16'd0;
			end
			OP_BEEP: begin
				el_n    = '0;
				play_n  = 1'b1;
				idx_n   = '0;
				time_n  = item_s1.period_ms;
				loop_n  = item_s1.loop_on;
				table_n = 1'b0;
				cnt_n   = CW'(BEEP_STEPS) + CW'(item_s1.loop_on);
				if (cfg.passive) begin
					hz_n = item_s1.tone_hz;
				end
				lvl_n = !cfg.passive;
				dhz_n = cfg.passive ? item_s1.tone_hz : 16'd0;
			end
			OP_ARRAY: begin
				el_n    = '0;
				play_n  = 1'b1;
				if (NW'(item_s1.entry_count) > NW'(DEPTH)) begin
					cnt_n = CW'(DEPTH);
				end else begin
					cnt_n = CW'(item_s1.entry_count);
				end
				idx_n   = '0;
				table_n = 1'b1;
				loop_n  = 1'b0;
				time_n  = rd_data.period_ms;
				hz_n    = rd_data.tone_hz;
				lvl_n   = !cfg.passive;
				dhz_n   = cfg.passive ? rd_data.tone_hz : 16'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			el_q    <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			time_q  <= '0;
			hz_q    <= '0;
			loop_q  <= 1'b0;
			table_q <= 1'b0;
			play_q  <= 1'b0;
			lvl_q   <= 1'b0;
			dhz_q   <= '0;
		end else if (move) begin
			el_q    <= el_n;
			idx_q   <= idx_n;
			cnt_q   <= cnt_n;
			time_q  <= time_n;
			hz_q    <= hz_n;
			loop_q  <= loop_n;
			table_q <= table_n;
			play_q  <= play_n;
			lvl_q   <= lvl_n;
			dhz_q   <= dhz_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (move) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_q.gpio_level <= cfg.passive ? 1'b0 : lvl_n;
			res_q.tone_hz    <= cfg.passive ? dhz_n : 16'd0;
			res_q.playing    <= play_n;
			res_q.done       <= done_n;
		end
	end

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done |-> !res_q.playing)
		else $error("finished pattern still reported as playing");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !move |=> valid_s1 && $stable(idx_q) && $stable(el_q))
		else $error("stalled command lost or state changed");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(idx_q) <= (CW+1)'(DEPTH))
		else $error("step index beyond table depth");

	a_one_drive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.gpio_level && (res_q.tone_hz != '0)))
		else $error("gpio and tone driven together");

endmodule

`default_nettype wire

// ===== hdl/buzzer_tone_sequencer.sv =====
// Top level of the buzzer tone sequencer: register port, table access and sequencer.
// Usage: commands enter on the item channel (item_valid/item_ready) and every
// command gives exactly one result transfer on the res channel (res_valid/res_ready).
// A tick command advances time by tick_ms; stop, turn-on, beep, load entry and
// start array control the pattern. The result carries the GPIO level, the tone
// frequency, the playing flag and a done pulse for a finished beep or array.
// An accepted command waits in the update stage; its result is registered when that
// stage moves. Unless results stall, one command is taken per cycle; the limit is
// the single update stage, whose step table read is issued at the accepting edge
// using the state left by the command ahead. Table loads write at the accepting edge.
// When the receiver stalls, the result register holds and the update stage
// still takes one more command; the item channel then waits until it moves.
// Reset clears all sequencer state, sets tick_ms to 1 and the active buzzer
// type; the step table is not cleared and must be loaded before an array runs.
// The APB-style port holds tick_ms at address 0 and passive_mode at address 4.
`default_nettype none

module buzzer_tone_sequencer
	import bts_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [2:0]  opcode,
	input  wire logic [15:0] tone_hz,
	input  wire logic [15:0] period_ms,
	input  wire logic        loop_on,
	input  wire logic [5:0]  entry_index,
	input  wire logic [6:0]  entry_count,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic             gpio_level,
	output logic [15:0]      tone_out_hz,
	output logic             is_playing,
	output logic             done_res
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (AW > 6) ? AW : 6;

	cfg_t          cfg_q;
	item_t         item;
	result_t       res;
	entry_t        wr_data;
	entry_t        rd_data;
	logic          accept;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] idx_after;
	logic [CW:0]   rd_next;
	logic [IW:0]   wr_idx;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_ms <= TICK_MS_RESET;
			cfg_q.passive <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_TICK_MS: cfg_q.tick_ms <= pwdata[9:0];
				REG_PASSIVE: cfg_q.passive <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TICK_MS: prdata = {22'd0, cfg_q.tick_ms};
			REG_PASSIVE: prdata = {31'd0, cfg_q.passive};
			default:     prdata = '0;
		endcase
	end

	assign item.op          = op_t'(opcode);
	assign item.tone_hz     = tone_hz;
	assign item.period_ms   = period_ms;
	assign item.loop_on     = loop_on;
	assign item.entry_count = entry_count;

	assign accept  = item_valid && item_ready;
	assign wr_idx  = (IW+1)'(entry_index);
	assign wr_en   = accept && (item.op == OP_LOAD) && (wr_idx < (IW+1)'(TABLE_DEPTH));
	assign wr_data = '{period_ms: period_ms, tone_hz: tone_hz};
	assign rd_en   = accept && ((item.op == OP_TICK) || (item.op == OP_ARRAY));
	assign rd_next = (CW+1)'(idx_after) + (CW+1)'(1);
	assign rd_addr = (item.op == OP_ARRAY) ? '0 : rd_next[AW-1:0];

	bts_table #(
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bts_seq #(
		.DEPTH (TABLE_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.rd_data    (rd_data),
		.idx_after  (idx_after),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	assign gpio_level  = res.gpio_level;
	assign tone_out_hz = res.tone_hz;
	assign is_playing  = res.playing;
	assign done_res    = res.done;

endmodule

`default_nettype wire

// ===== dv/buzzer_tone_sequencer_tb.sv =====
// Self-checking testbench for the buzzer tone sequencer: command stimulus, drive prediction, result checks.
module buzzer_tone_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bts_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_LIMIT = 10;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] tone_hz;
		logic [15:0] period_ms;
		logic        loop_on;
		logic [5:0]  entry_index;
		logic [6:0]  entry_count;
	} buzzer_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [2:0]  opcode = '0;
	logic [15:0] tone_hz = '0;
	logic [15:0] period_ms = '0;
	logic        loop_on = 1'b0;
	logic [5:0]  entry_index = '0;
	logic [6:0]  entry_count = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic        gpio_level;
	logic [15:0] tone_out_hz;
	logic        is_playing;
	logic        done_res;

	buzzer_tone_sequencer #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted sequencer state and configuration.
	logic [9:0]  cfg_tick = TICK_MS_RESET;
	logic        cfg_passive = 1'b0;
	logic [31:0] elapsed = '0;
	logic [6:0]  step_idx = '0;
	logic [6:0]  step_cnt = '0;
	logic [15:0] step_ms = '0;
	logic [15:0] cur_hz = '0;
	logic        looping_q = 1'b0;
	logic        array_mode = 1'b0;
	logic        playing_q = 1'b0;
	logic        level_q = 1'b0;
	logic [15:0] hz_q = '0;
	logic [15:0] period_mem [TABLE_DEPTH];
	logic [15:0] tone_mem [TABLE_DEPTH];

	buzzer_cmd_t pending_cmds [$];
	result_t     drive_expected [$];
	buzzer_cmd_t on_bus;
	logic        offering = 1'b0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_request = 1'b0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          mismatches = 0;
	int          results_seen = 0;
	int          issued = 0;
	int          gen_tick = 1;
	logic [TABLE_DEPTH-1:0] table_loaded = '0;

	function automatic void sound();
		level_q = !cfg_passive;
		hz_q = cfg_passive ? cur_hz : 16'd0;
	endfunction

	function automatic void silence();
		level_q = 1'b0;
		hz_q = '0;
	endfunction

	function automatic logic advance_time();
		logic [32:0] sum;
		logic [6:0]  nxt;
		sum = {1'b0, elapsed} + 33'(cfg_tick);
		elapsed = sum[32] ? '1 : sum[31:0];
		if (!playing_q || step_cnt == 0 || elapsed <= {16'd0, step_ms})
			return 1'b0;
		elapsed = '0;
		nxt = step_idx + 7'd1;
		if (nxt < step_cnt) begin
			if (!array_mode) begin
				if (looping_q)
					nxt = nxt & 7'd1;
				if (nxt[0])
					silence();
				else
					sound();
			end else begin
				step_ms = period_mem[nxt[5:0]];
				cur_hz = tone_mem[nxt[5:0]];
				sound();
			end
			step_idx = nxt;
			return 1'b0;
		end
		step_idx = nxt;
		silence();
		playing_q = 1'b0;
		return 1'b1;
	endfunction

	function automatic result_t predict_drive(buzzer_cmd_t c);
		result_t r;
		logic    finished;
		finished = 1'b0;
		case (c.opcode)
			OP_TICK: finished = advance_time();
			OP_STOP: begin
				playing_q = 1'b0;
				silence();
			end
			OP_TURN_ON: begin
				elapsed = '0;
				playing_q = 1'b1;
				looping_q = 1'b0;
				step_cnt = '0;
				if (cfg_passive)
					cur_hz = c.tone_hz;
				sound();
			end
			OP_BEEP: begin
				elapsed = '0;
				playing_q = 1'b1;
				step_idx = '0;
				step_ms = c.period_ms;
				looping_q = c.loop_on;
				array_mode = 1'b0;
				step_cnt = 7'(BEEP_STEPS) + 7'(c.loop_on);
				if (cfg_passive)
					cur_hz = c.tone_hz;
				sound();
			end
			OP_LOAD: begin
				period_mem[c.entry_index] = c.period_ms;
				tone_mem[c.entry_index] = c.tone_hz;
			end
			OP_ARRAY: begin
				elapsed = '0;
				playing_q = 1'b1;
				step_cnt = (c.entry_count > TABLE_DEPTH) ? 7'(TABLE_DEPTH) : c.entry_count;
				step_idx = '0;
				array_mode = 1'b1;
				looping_q = 1'b0;
				step_ms = period_mem[0];
				cur_hz = tone_mem[0];
				sound();
			end
			default: ;
		endcase
		r.gpio_level = cfg_passive ? 1'b0 : level_q;
		r.tone_hz = cfg_passive ? hz_q : 16'd0;
		r.playing = playing_q;
		r.done = finished;
		return r;
	endfunction

	always @(posedge clk) begin
		if (item_valid && item_ready) begin
			drive_expected.push_back(predict_drive(on_bus));
			offering = 1'b0;
		end
		if (!offering && pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			on_bus = pending_cmds.pop_front();
			offering = 1'b1;
			opcode <= on_bus.opcode;
			tone_hz <= on_bus.tone_hz;
			period_ms <= on_bus.period_ms;
			loop_on <= on_bus.loop_on;
			entry_index <= on_bus.entry_index;
			entry_count <= on_bus.entry_count;
		end
		item_valid <= offering;
	end

	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_request) begin
			hold_left <= HOLD_CYCLES;
			hold_request = 1'b0;
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (res_valid && res_ready) begin
			got = {gpio_level, tone_out_hz, is_playing, done_res};
			results_seen++;
			if (drive_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result %0d arrived with no command outstanding", results_seen);
			end else begin
				want = drive_expected.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result %0d: expected gpio=%0b tone=%0d playing=%0b done=%0b, got gpio=%0b tone=%0d playing=%0b done=%0b",
							results_seen, want.gpio_level, want.tone_hz, want.playing,
							want.done, got.gpio_level, got.tone_hz, got.playing, got.done);
				end
			end
		end
		res_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic buzzer_cmd_t random_cmd(logic [2:0] op);
		buzzer_cmd_t c;
		c.opcode = op;
		c.tone_hz = 16'($urandom);
		c.period_ms = 16'($urandom);
		c.loop_on = 1'($urandom);
		c.entry_index = 6'($urandom);
		c.entry_count = 7'($urandom);
		return c;
	endfunction

	function automatic buzzer_cmd_t make_cmd(logic [2:0] op, logic [15:0] hz, logic [15:0] per,
			logic lp, logic [5:0] idx, logic [6:0] cnt);
		buzzer_cmd_t c;
		c = '{op, hz, per, lp, idx, cnt};
		return c;
	endfunction

	function automatic logic [15:0] pick_period();
		if (gen_tick >= 500 && $urandom_range(15) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 2 * gen_tick));
	endfunction

	task automatic push_cmd(buzzer_cmd_t c);
		pending_cmds.push_back(c);
		if (c.opcode == OP_LOAD)
			table_loaded[c.entry_index] = 1'b1;
		issued++;
	endtask

	task automatic queue_ticks(int n);
		repeat (n) push_cmd(random_cmd(OP_TICK));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_cmds.size() != 0 || offering || drive_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic apb_write(logic reg_sel, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_TICK_MS)
			cfg_tick = data[9:0];
		else
			cfg_passive = data[0];
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int tick, logic passive, int n_items,
			logic pressure);
		buzzer_cmd_t c;
		int sel, n, k, ticks_needed, prefix, target;
		wait_idle();
		apb_write(REG_TICK_MS, 32'(tick));
		apb_write(REG_PASSIVE, 32'(passive));
		@(negedge clk);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		gen_tick = tick;
		target = issued + n_items;
		while (issued < target) begin
			sel = $urandom_range(99);
			if (sel < 35) begin
				n = ($urandom_range(11) == 0) ? TABLE_DEPTH : $urandom_range(1, 8);
				ticks_needed = 0;
				for (int i = 0; i < n; i++) begin
					c = random_cmd(OP_LOAD);
					c.entry_index = 6'(i);
					c.period_ms = pick_period();
					ticks_needed += c.period_ms / gen_tick + 1;
					push_cmd(c);
				end
				c = random_cmd(OP_ARRAY);
				c.entry_count = (n == TABLE_DEPTH) ? 7'($urandom_range(TABLE_DEPTH, 127)) : 7'(n);
				if ($urandom_range(9) == 0)
					c.entry_count = '0;
				push_cmd(c);
				if ($urandom_range(3) == 0 || c.entry_count == 0) begin
					queue_ticks($urandom_range(0, ticks_needed));
					push_cmd(random_cmd(OP_STOP));
				end else
					queue_ticks(ticks_needed + $urandom_range(0, 2));
			end else if (sel < 60) begin
				c = random_cmd(OP_BEEP);
				c.period_ms = pick_period();
				push_cmd(c);
				k = c.period_ms / gen_tick + 1;
				if (c.loop_on) begin
					queue_ticks(k * $urandom_range(1, 5));
					push_cmd(random_cmd(OP_STOP));
				end else if ($urandom_range(3) == 0)
					queue_ticks($urandom_range(0, 2 * k));
				else
					queue_ticks(2 * k + $urandom_range(0, 2));
			end else if (sel < 72) begin
				push_cmd(random_cmd(OP_TURN_ON));
				queue_ticks($urandom_range(0, 4));
				if ($urandom_range(1) == 0)
					push_cmd(random_cmd(OP_STOP));
			end else begin
				repeat ($urandom_range(1, 4)) begin
					c = random_cmd(3'($urandom_range(0, 7)));
					if (c.opcode == OP_ARRAY) begin
						for (prefix = 0; prefix < TABLE_DEPTH && table_loaded[prefix]; prefix++);
						if (prefix == 0)
							c.opcode = OP_TICK;
						else if (prefix < TABLE_DEPTH)
							c.entry_count = 7'($urandom_range(0, prefix));
					end
					push_cmd(c);
				end
			end
		end
		if (pressure)
			hold_request = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();
		apb_write(REG_TICK_MS, 32'd1);
		apb_write(REG_PASSIVE, 32'd0);
		@(negedge clk);
		gen_tick = 1;
		// Idle tick, unknown opcodes and turn-on that ticks never end.
		push_cmd(make_cmd(OP_TICK, '1, '1, 1'b1, '1, '1));
		push_cmd(make_cmd(OP_SPARE_6, '1, '1, 1'b1, '1, '1));
		push_cmd(make_cmd(OP_SPARE_7, '0, '0, 1'b0, '0, '0));
		push_cmd(make_cmd(OP_TURN_ON, 16'hFFFF, '0, 1'b0, '0, '0));
		queue_ticks(1);
		push_cmd(make_cmd(OP_STOP, '0, '0, 1'b0, '0, '0));
		// One-shot beep with zero period, then a looping beep toggled twice.
		push_cmd(make_cmd(OP_BEEP, 16'd1, 16'd0, 1'b0, '0, '0));
		queue_ticks(2);
		push_cmd(make_cmd(OP_BEEP, 16'hFFFF, 16'd1, 1'b1, '0, '0));
		queue_ticks(4);
		push_cmd(make_cmd(OP_STOP, '0, '0, 1'b0, '0, '0));
		// Table extremes, an empty array that holds entry zero, and a two-step array.
		push_cmd(make_cmd(OP_LOAD, 16'hFFFF, 16'd0, 1'b0, 6'd0, '0));
		push_cmd(make_cmd(OP_LOAD, 16'd0, 16'd2, 1'b0, 6'd1, '0));
		push_cmd(make_cmd(OP_LOAD, 16'h1234, 16'hFFFF, 1'b0, 6'd63, '0));
		push_cmd(make_cmd(OP_ARRAY, '0, '0, 1'b0, '0, 7'd0));
		queue_ticks(1);
		push_cmd(make_cmd(OP_STOP, '0, '0, 1'b0, '0, '0));
		push_cmd(make_cmd(OP_ARRAY, '0, '0, 1'b0, '0, 7'd2));
		queue_ticks(4);
		run_phase(0, 0, 1, 1'b0, 250, 1'b1);
		run_phase(84, 0, 1000, 1'b1, 280, 1'b0);
		run_phase(0, 84, 3, 1'b1, 280, 1'b0);
		run_phase(12, 12, 1000, 1'b0, 280, 1'b1);
		run_phase(0, 0, $urandom_range(1, 1000), 1'b1, 300, 1'b0);
		run_phase(12, 12, $urandom_range(1, 1000), 1'b0, 300, 1'b0);
		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
